// ===== sv/epv_pkg.sv =====
package epv_pkg;

  // field and state widths
  localparam int CNT_W   = 32;  // encoder counter width in use
  localparam int FRAC_W  = 16;  // fraction bits of the gains
  localparam int DATA_W  = 32;  // port and gain width
  localparam int THR_W   = 31;
  localparam int AVG_W   = 16;
  localparam int WCNT_W  = AVG_W + 1;
  localparam int WSUM_W  = 48;
  localparam int POS_W   = DATA_W + 1;
  localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;

  // split multiplier
  localparam int SPLIT   = WSUM_W / 2;
  localparam int PL_W    = SPLIT + 1 + DATA_W;
  localparam int PH_W    = WSUM_W - SPLIT + DATA_W;
  localparam int PROD_W  = WSUM_W + DATA_W;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVERSE_DIR     = 3'd0,
    CFG_ORIGIN_COUNT    = 3'd1,
    CFG_POSITION_GAIN   = 3'd2,
    CFG_FAST_SPEED_GAIN = 3'd3,
    CFG_SLOW_SPEED_GAIN = 3'd4,
    CFG_SLOW_THRESHOLD  = 3'd5,
    CFG_AVERAGE_WINDOW  = 3'd6
  } cfg_idx_t;

  localparam logic signed [DATA_W-1:0] GAIN_ONE = DATA_W'(1) <<< FRAC_W;
  localparam logic signed [DATA_W-1:0] OUT_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] OUT_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ===== sv/epv_mul_sat.sv =====
module epv_mul_sat (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [epv_pkg::WSUM_W-1:0]  x_i,
  input  logic signed [epv_pkg::DATA_W-1:0]  g_i,
  output logic signed [epv_pkg::DATA_W-1:0]  y_o
);
  import epv_pkg::*;

  logic signed [PL_W-1:0]   pl_r;
  logic signed [PH_W-1:0]   ph_r;
  logic signed [PROD_W-1:0] full;
  logic signed [PROD_W-1:0] shifted;
  logic                     all_zero;
  logic                     all_one;

  // two partial products, low half taken unsigned
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= $signed({1'b0, x_i[SPLIT-1:0]}) * g_i;
      ph_r <= $signed(x_i[WSUM_W-1:SPLIT]) * g_i;
    end
  end

  always_comb begin
    full     = $signed({ph_r, {SPLIT{1'b0}}}) +
               $signed({{(PROD_W-PL_W){pl_r[PL_W-1]}}, pl_r});
    shifted  = full >>> FRAC_W;
    all_zero = ~|shifted[PROD_W-1:DATA_W-1];
    all_one  = &shifted[PROD_W-1:DATA_W-1];
    if (all_zero || all_one) begin
      y_o = shifted[DATA_W-1:0];
    end else if (shifted[PROD_W-1]) begin
      y_o = OUT_MIN;
    end else begin
      y_o = OUT_MAX;
    end
  end

endmodule

// ===== sv/encoder_position_velocity.sv =====
// encoder position and velocity estimator
//
// input channel: one encoder count beat per control period on in_encoder_count,
// taken when in_valid is high and in_stall is low
// result channel: one beat per input beat carrying out_position,
// out_velocity and out_velocity_fresh, taken when out_valid is high and
// out_stall is low
// config port: cfg_we writes cfg_wdata to the register selected by cfg_index
// in one cycle; write only while no beat is in flight
//
// latency is 4 cycles from an input beat to its result beat: input register,
// state/operand stage, partial-product stage, result register
// throughput is one beat per cycle; each of the four stages holds its beat
// only while the stage after it is full and blocked, so a stalled result
// still lets new beats fill the bubbles behind it
//
// synchronous reset clears all stages, the window state, the last count
// and the held velocity, and loads the register defaults (unit gains)
module encoder_position_velocity (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [epv_pkg::DATA_W-1:0]   in_encoder_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [epv_pkg::DATA_W-1:0]   out_position,
  output logic signed [epv_pkg::DATA_W-1:0]   out_velocity,
  output logic                                out_velocity_fresh,
  input  logic                                cfg_we,
  input  logic        [epv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [epv_pkg::DATA_W-1:0]   cfg_wdata
);
  import epv_pkg::*;

  // configuration registers
  logic                     reverse_dir_r;
  logic signed [DATA_W-1:0] origin_r;
  logic signed [DATA_W-1:0] pos_gain_r;
  logic signed [DATA_W-1:0] fast_gain_r;
  logic signed [DATA_W-1:0] slow_gain_r;
  logic        [THR_W-1:0]  thr_r;
  logic        [AVG_W-1:0]  avg_r;

  // estimator state
  logic        [CNT_W-1:0]  last_r;
  logic        [WCNT_W-1:0] wcnt_r;
  logic signed [WSUM_W-1:0] wsum_r;

  // pipeline stages
  logic                     v0_r, v1_r, v2_r, v3_r;
  logic                     rdy0, rdy1, rdy2, rdy3;
  logic        [CNT_W-1:0]  cnt0_r;
  logic                     fresh1_r, fresh2_r;
  logic signed [WSUM_W-1:0] xv1_r, xp1_r;
  logic signed [DATA_W-1:0] gv1_r;
  logic signed [DATA_W-1:0] y_pos, y_vel;

  // stage 1 combinational work
  logic        [CNT_W-1:0]  raw;
  logic        [CNT_W-1:0]  delta;
  logic        [CNT_W-1:0]  mag;
  logic signed [POS_W-1:0]  pos_diff;
  logic                     slow;
  logic        [WCNT_W-1:0] wcnt_inc;
  logic signed [WSUM_W:0]   sum_wide;
  logic signed [WSUM_W-1:0] sum_sat;
  logic                     win_done;
  logic        [WCNT_W-1:0] wcnt_nxt;
  logic signed [WSUM_W-1:0] wsum_nxt;
  logic                     fresh_nxt;
  logic signed [WSUM_W-1:0] xv_nxt;
  logic signed [DATA_W-1:0] gv_nxt;

  // a stage moves when it is empty or the next one moves
  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_stall = !rdy0;
  assign out_valid = v3_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_dir_r <= 1'b0;
      origin_r      <= '0;
      pos_gain_r    <= GAIN_ONE;
      fast_gain_r   <= GAIN_ONE;
      slow_gain_r   <= GAIN_ONE;
      thr_r         <= '0;
      avg_r         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_REVERSE_DIR:     reverse_dir_r <= cfg_wdata[0];
        CFG_ORIGIN_COUNT:    origin_r      <= cfg_wdata;
        CFG_POSITION_GAIN:   pos_gain_r    <= cfg_wdata;
        CFG_FAST_SPEED_GAIN: fast_gain_r   <= cfg_wdata;
        CFG_SLOW_SPEED_GAIN: slow_gain_r   <= cfg_wdata;
        CFG_SLOW_THRESHOLD:  thr_r         <= cfg_wdata[THR_W-1:0];
        CFG_AVERAGE_WINDOW:  avg_r         <= cfg_wdata[AVG_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // direction, delta, mode select and window update
  always_comb begin
    raw      = reverse_dir_r ? (CNT_W'(0) - cnt0_r) : cnt0_r;
    delta    = raw - last_r;  // wraps at counter width
    mag      = delta[CNT_W-1] ? (CNT_W'(0) - delta) : delta;
    slow     = CMP_W'(mag) < CMP_W'(thr_r);
    pos_diff = $signed({{(POS_W-CNT_W){raw[CNT_W-1]}}, raw}) -
               $signed({origin_r[DATA_W-1], origin_r});

    wcnt_inc = wcnt_r + WCNT_W'(1);
    sum_wide = $signed({wsum_r[WSUM_W-1], wsum_r}) +
               $signed({{(WSUM_W+1-CNT_W){delta[CNT_W-1]}}, delta});
    if (sum_wide[WSUM_W] != sum_wide[WSUM_W-1]) begin
      sum_sat = sum_wide[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}}
                                 : {1'b0, {(WSUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[WSUM_W-1:0];
    end
    win_done = wcnt_inc > WCNT_W'(avg_r);

    if (!slow) begin
      // fast mode: one-period delta, window restarts
      wcnt_nxt  = '0;
      wsum_nxt  = '0;
      fresh_nxt = 1'b1;
      xv_nxt    = $signed({{(WSUM_W-CNT_W){delta[CNT_W-1]}}, delta});
      gv_nxt    = fast_gain_r;
    end else if (win_done) begin
      wcnt_nxt  = '0;
      wsum_nxt  = '0;
      fresh_nxt = 1'b1;
      xv_nxt    = sum_sat;
      gv_nxt    = slow_gain_r;
    end else begin
      wcnt_nxt  = wcnt_inc;
      wsum_nxt  = sum_sat;
      fresh_nxt = 1'b0;
      xv_nxt    = sum_sat;
      gv_nxt    = slow_gain_r;
    end
  end

  // stage valids and estimator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      last_r <= '0;
      wcnt_r <= '0;
      wsum_r <= '0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy1 && v0_r) begin
        last_r <= raw;
        wcnt_r <= wcnt_nxt;
        wsum_r <= wsum_nxt;
      end
    end
  end

  // payload registers of stages 0 to 2
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      cnt0_r <= in_encoder_count[CNT_W-1:0];
    end
    if (rdy1 && v0_r) begin
      fresh1_r <= fresh_nxt;
      xv1_r    <= xv_nxt;
      gv1_r    <= gv_nxt;
      xp1_r    <= $signed({{(WSUM_W-POS_W){pos_diff[POS_W-1]}}, pos_diff});
    end
    if (rdy2 && v1_r) begin
      fresh2_r <= fresh1_r;
    end
  end

  epv_mul_sat u_mul_pos (
    .clk (clk),
    .en  (rdy2 && v1_r),
    .x_i (xp1_r),
    .g_i (pos_gain_r),
    .y_o (y_pos)
  );

  epv_mul_sat u_mul_vel (
    .clk (clk),
    .en  (rdy2 && v1_r),
    .x_i (xv1_r),
    .g_i (gv1_r),
    .y_o (y_vel)
  );

  // result register; out_velocity doubles as the held velocity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_velocity <= '0;
    end else if (rdy3 && v2_r && fresh2_r) begin
      out_velocity <= y_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      out_position       <= y_pos;
      out_velocity_fresh <= fresh2_r;
    end
  end

endmodule

// ===== sv/epv_checker.sv =====
module epv_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [epv_pkg::DATA_W-1:0]   out_position,
  input logic signed [epv_pkg::DATA_W-1:0]   out_velocity,
  input logic                                out_velocity_fresh
);
  import epv_pkg::*;

  logic [2:0]               pend_r;
  logic signed [DATA_W-1:0] last_vel_r;
  logic                     in_beat, out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      last_vel_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_beat) - 3'(out_beat);
      if (out_beat) last_vel_r <= out_velocity;
    end
  end

  // a result beat never comes without an input beat in flight
  a_no_extra_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result beat without pending input beat");

  // the four stages bound the beats in flight
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("more beats in flight than stages");

  // a stale velocity repeats the last delivered one
  a_vel_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_velocity_fresh |-> out_velocity == last_vel_r)
    else $error("held velocity changed without a fresh update");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position) &&
      $stable(out_velocity) && $stable(out_velocity_fresh))
    else $error("stalled result beat changed");

endmodule

bind encoder_position_velocity epv_checker u_epv_checker (.*);

// ===== tb/epv_checker.sv =====
`timescale 1ns / 1ps

module epv_scoreboard (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [epv_pkg::DATA_W-1:0]    in_encoder_count,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [epv_pkg::DATA_W-1:0]    out_position,
  input  logic signed [epv_pkg::DATA_W-1:0]    out_velocity,
  input  logic                                 out_velocity_fresh,
  input  logic                                 cfg_we,
  input  logic        [epv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [epv_pkg::DATA_W-1:0]    cfg_wdata,
  output int                                   mismatch_count,
  output int                                   motion_waiting
);
  import epv_pkg::*;

  localparam longint WSUM_MAX = (64'sd1 <<< (WSUM_W - 1)) - 1;
  localparam longint WSUM_MIN = -WSUM_MAX - 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
    logic                     fresh;
  } motion_t;

  // register copies
  logic                     rev;
  logic signed [DATA_W-1:0] origin;
  logic signed [DATA_W-1:0] pos_gain;
  logic signed [DATA_W-1:0] fast_gain;
  logic signed [DATA_W-1:0] slow_gain;
  logic        [THR_W-1:0]  slow_thr;
  logic        [AVG_W-1:0]  avg_win;

  // estimator state
  logic        [CNT_W-1:0]  prev_count;
  int unsigned              win_cnt;
  longint                   win_sum;
  logic signed [DATA_W-1:0] held_vel;

  motion_t motion_q[$];
  int      errs = 0;

  // floor(x * g / 2^F), clamped to 32 bits
  function automatic logic signed [DATA_W-1:0] scale_sat(input longint x,
                                                        input logic signed [DATA_W-1:0] g);
    logic signed [95:0] prod;
    prod = x * g;
    prod = prod >>> FRAC_W;
    if (prod > OUT_MAX) return OUT_MAX;
    if (prod < OUT_MIN) return OUT_MIN;
    return prod[DATA_W-1:0];
  endfunction

  function automatic motion_t advance_estimator(input logic [CNT_W-1:0] sample);
    logic [CNT_W-1:0] raw;
    logic [CNT_W-1:0] diff;
    longint           cur;
    longint           delta;
    longint           mag;
    longint           sum;
    motion_t          m;
    raw = rev ? -sample : sample;
    diff = raw - prev_count;
    cur = $signed(raw);
    delta = $signed(diff);
    prev_count = raw;
    m.position = scale_sat(cur - longint'(origin), pos_gain);
    m.fresh = 1'b0;
    mag = (delta < 0) ? -delta : delta;
    if (mag < longint'(slow_thr)) begin
      win_cnt++;
      sum = win_sum + delta;
      if (sum > WSUM_MAX) sum = WSUM_MAX;
      if (sum < WSUM_MIN) sum = WSUM_MIN;
      win_sum = sum;
      if (win_cnt > avg_win) begin
        win_cnt = 0;
        held_vel = scale_sat(win_sum, slow_gain);
        win_sum = 0;
        m.fresh = 1'b1;
      end
    end else begin
      held_vel = scale_sat(delta, fast_gain);
      win_cnt = 0;
      win_sum = 0;
      m.fresh = 1'b1;
    end
    m.velocity = held_vel;
    return m;
  endfunction

  always @(posedge clk) begin
    motion_t want;
    motion_t got;
    if (!rst_n) begin
      rev = 1'b0;
      origin = '0;
      pos_gain = GAIN_ONE;
      fast_gain = GAIN_ONE;
      slow_gain = GAIN_ONE;
      slow_thr = '0;
      avg_win = '0;
      prev_count = '0;
      win_cnt = 0;
      win_sum = 0;
      held_vel = '0;
      motion_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_position, out_velocity, out_velocity_fresh};
        if (motion_q.size() == 0) begin
          errs++;
          $display("%0t: result beat with none expected, actual position %0d velocity %0d",
                   $time, got.position, got.velocity);
        end else begin
          want = motion_q.pop_front();
          if (got.position !== want.position) begin
            errs++;
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, want.position, got.position);
          end
          if (got.velocity !== want.velocity) begin
            errs++;
            $display("%0t: velocity mismatch, expected %0d, actual %0d",
                     $time, want.velocity, got.velocity);
          end
          if (got.fresh !== want.fresh) begin
            errs++;
            $display("%0t: velocity_fresh mismatch, expected %0b, actual %0b",
                     $time, want.fresh, got.fresh);
          end
        end
      end
      if (in_valid && !in_stall)
        motion_q.push_back(advance_estimator(in_encoder_count));
      if (cfg_we) begin
        case (cfg_index)
          CFG_REVERSE_DIR:     rev = cfg_wdata[0];
          CFG_ORIGIN_COUNT:    origin = cfg_wdata;
          CFG_POSITION_GAIN:   pos_gain = cfg_wdata;
          CFG_FAST_SPEED_GAIN: fast_gain = cfg_wdata;
          CFG_SLOW_SPEED_GAIN: slow_gain = cfg_wdata;
          CFG_SLOW_THRESHOLD:  slow_thr = cfg_wdata[THR_W-1:0];
          CFG_AVERAGE_WINDOW:  avg_win = cfg_wdata[AVG_W-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count <= errs;
    motion_waiting <= motion_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import epv_pkg::*;

  // index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam int BLOCK_BEATS = 50;
  localparam int BLOCKS      = 4;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_encoder_count;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_position;
  logic signed [DATA_W-1:0] out_velocity;
  logic                     out_velocity_fresh;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_wdata;
  int                       mismatch_count;
  int                       motion_waiting;

  // idling knobs and hold-off request toward the result side
  int                       send_gap_pct;
  int                       recv_stall_pct;
  int                       hold_len;
  int                       hold_req_seq;

  // stimulus shaping: last count sent and the threshold in force
  logic [DATA_W-1:0]        last_sent;
  int unsigned              cur_thr;

  encoder_position_velocity uut (.*);

  epv_scoreboard u_scoreboard (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // result side: random stall, or a long hold-off counted here when asked
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req_seq) begin
        hold_seen = hold_req_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one count beat, after a random gap, and wait until it is taken
  // valid stays high on return so back-to-back beats never toggle it
  task automatic send_count(input logic [DATA_W-1:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_encoder_count <= v;
    do @(posedge clk); while (in_stall);
    last_sent = v;
  endtask

  // stop offering and wait until every predicted result beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (motion_waiting != 0);
  endtask

  // one register write, we stays high so a following write needs no toggle
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // full register set, written only once the pipe is empty
  task automatic load_settings(input logic rev, input logic [DATA_W-1:0] org,
                               input logic [DATA_W-1:0] pg, input logic [DATA_W-1:0] fg,
                               input logic [DATA_W-1:0] sg, input logic [DATA_W-1:0] thr,
                               input logic [AVG_W-1:0] win);
    drain();
    // upper bits of the narrow registers carry junk that must be ignored
    put_reg(CFG_REVERSE_DIR, {31'($urandom), rev});
    put_reg(CFG_ORIGIN_COUNT, org);
    put_reg(CFG_POSITION_GAIN, pg);
    put_reg(CFG_FAST_SPEED_GAIN, fg);
    put_reg(CFG_SLOW_SPEED_GAIN, sg);
    put_reg(CFG_SLOW_THRESHOLD, thr);
    put_reg(CFG_AVERAGE_WINDOW, {16'($urandom), win});
    put_reg(CFG_UNMAPPED, $urandom);
    cfg_we <= 1'b0;
    cur_thr = thr[THR_W-1:0];
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(9))
      0: return OUT_MAX;
      1: return OUT_MIN;
      2: return '0;
      3: return GAIN_ONE;
      4, 5: return $urandom;
      default: return $urandom_range(1 << 20) - (1 << 19);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_threshold();
    case ($urandom_range(9))
      0: return '0;
      1: return 1;
      2: return $urandom_range(64);
      3: return $urandom_range(8000);
      4: return $urandom;
      5: return 32'h7FFF_FFFF;
      default: return $urandom_range(3000);
    endcase
  endfunction

  function automatic logic [AVG_W-1:0] pick_window();
    case ($urandom_range(19))
      0: return '1;
      1, 2, 3: return '0;
      4, 5, 6, 7, 8: return AVG_W'($urandom_range(20));
      default: return AVG_W'($urandom_range(3));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_origin();
    case ($urandom_range(5))
      0: return OUT_MIN;
      1: return OUT_MAX;
      2: return '0;
      3: return $urandom;
      default: return last_sent + $urandom_range(2000) - 1000;
    endcase
  endfunction

  // encoder-like walk: mostly small steps inside the slow band, some steps
  // straddling the threshold, a few exactly on it and a few wild jumps
  function automatic logic [DATA_W-1:0] next_count(input logic [DATA_W-1:0] prev,
                                                   input int unsigned thr);
    int unsigned span;
    int unsigned r;
    span = (thr > 1) ? ((thr - 1 > 1000) ? 1000 : thr - 1) : 0;
    r = $urandom_range(19);
    if (r < 2) return $urandom;
    if (r == 2) return $urandom_range(1) ? prev + thr : prev - thr;
    if (r < 6) return prev + $urandom_range(4 * span + 64) - (2 * span + 32);
    return prev + $urandom_range(2 * span) - span;
  endfunction

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_encoder_count <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    recv_stall_pct <= 74;
    hold_len <= 0;
    hold_req_seq <= 0;
    send_gap_pct = 10;
    last_sent = '0;
    cur_thr = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero threshold so every beat is fast mode,
    // first beat takes its delta from a zero last count
    send_count(32'h0000_0005);
    send_count(32'h0000_0000);
    send_count(32'h7FFF_FFFF);
    send_count(32'h8000_0000);
    send_count(32'hFFFF_FFFF);
    send_count(32'h0000_0001);

    // reversed mounting, extreme origin and gains, zero window
    load_settings(1'b1, OUT_MIN, OUT_MAX, OUT_MIN, 32'h0000_0001, 32'd100, 16'd0);
    send_count(32'h8000_0000);  // most negative count reversed onto itself
    send_count(32'h8000_0000);
    send_count(32'h7FFF_FFFF);
    send_count(32'h7FFF_FFF0);  // small delta, every slow beat updates
    send_count(32'h7FFF_FFE0);

    // widest threshold, window of six beats, left half full
    load_settings(1'b0, OUT_MAX, OUT_MIN, '0, OUT_MAX, 32'h7FFF_FFFF, 16'd5);
    send_count(32'd10);
    send_count(32'd12);
    send_count(32'd15);

    // window shortened while filling: the next slow beat must update
    load_settings(1'b0, OUT_MAX, OUT_MIN, GAIN_ONE, OUT_MAX, 32'h7FFF_FFFF, 16'd1);
    send_count(32'd20);
    send_count(32'd0);
    send_count(32'h8000_0000);  // delta magnitude 2^31, above any threshold

    // largest window with all-slow beats: velocity just holds
    load_settings(1'b1, '0, GAIN_ONE, GAIN_ONE, GAIN_ONE, 32'h7FFF_FFFF, 16'hFFFF);
    send_count(32'd100);
    send_count(32'd90);
    send_count(32'hFFFF_FF00);

    // random part: three idling regimes, several register settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 10;
          recv_stall_pct <= 74;
        end
        1: begin
          send_gap_pct = 74;
          recv_stall_pct <= 10;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct <= 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        load_settings(1'($urandom_range(1)), pick_origin(), pick_gain(), pick_gain(),
                      pick_gain(), pick_threshold(), pick_window());
        for (int n = 0; n < BLOCK_BEATS; n++) begin
          // long result hold-off while counts keep coming, fills the pipe
          if (n == 20) begin
            hold_len <= $urandom_range(40, 80);
            hold_req_seq <= hold_req_seq + 1;
          end
          send_count(next_count(last_sent, cur_thr));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && motion_waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
